// ===== src/sdq_pkg.sv =====
package sdq_pkg;

    // One stored event: species, reaction and delay time (unsigned Q16.16)
    typedef struct packed {
        logic [15:0] species;
        logic [15:0] reaction;
        logic [31:0] delay;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // Action codes
    localparam logic [1:0] ACT_INSERT  = 2'd0;
    localparam logic [1:0] ACT_EXTRACT = 2'd1;
    localparam logic [1:0] ACT_PEEK    = 2'd2;

    // Result status codes
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_EMPTY = 2'd2;

    // Register file: one 32-bit register, word index taken from paddr[2]
    localparam int         PADDR_W         = 3;
    localparam logic [0:0] REG_TIE_EPSILON = 1'b0;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_INS_SCAN,
        ST_INS_PUT,
        ST_PEEK_LD,
        ST_EXT_BOUND,
        ST_EXT_COUNT,
        ST_EMIT_RD,
        ST_EMIT_LD,
        ST_RESULT
    } state_t;

endpackage

// ===== src/sdq_ram.sv =====
module sdq_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== src/sorted_delay_event_queue_unit.sv =====
// Channel  | Direction | Handshake          | Payload
// ---------+-----------+--------------------+---------------------------------------------
// input    | in        | in_valid/in_stall  | action, species_id, reaction_id, delay_time
// result   | out       | out_valid/out_stall| status, out_species, out_reaction, out_time,
//          |           |                    | last, entries_in_use
// config   | in        | APB                | tie_epsilon at byte address 0
//
// Insert: one RAM step per entry behind the insertion point, each moving that entry back.
// Extract: a bound step, then count steps over the following entries until one lies past
// the bound or the tail is reached, then a read and a load step per result; the load waits
// while the result is stalled. Peek: dispatch, load, result; status-only results: dispatch,
// result. The single read/write port pair of the entry RAM and the one comparator set these
// steps; in_stall is high while an item is worked.
// Reset clears the state, count, head pointer, output valid and tie epsilon; the RAM needs no clearing pass.
// A stalled result holds; the next item is taken while the last result waits.
module sorted_delay_event_queue_unit #(
    parameter int CAPACITY = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,

    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [1:0]                   action,
    input  logic [15:0]                  species_id,
    input  logic [15:0]                  reaction_id,
    input  logic [31:0]                  delay_time,

    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [1:0]                   status,
    output logic [15:0]                  out_species,
    output logic [15:0]                  out_reaction,
    output logic [31:0]                  out_time,
    output logic                         last,
    output logic [5:0]                   entries_in_use,

    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [sdq_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
    localparam logic [CNT_W-1:0] CNT_CAP = CNT_W'(CAPACITY);
    localparam int ENTRY_W_L = sdq_pkg::ENTRY_W;

    // Logical position to physical RAM address around the ring
    function automatic logic [ADDR_W-1:0] wrap(input logic [ADDR_W-1:0] base,
                                               input logic [CNT_W-1:0]  off);
        logic [CNT_W:0] sum;
        sum = (CNT_W+1)'(base) + (CNT_W+1)'(off);
        if (sum >= (CNT_W+1)'(CAPACITY))
        begin
            sum = sum - (CNT_W+1)'(CAPACITY);
        end
        return sum[ADDR_W-1:0];
    endfunction

    sdq_pkg::state_t state_reg, state_next;

    logic [1:0]          act_reg, act_next;
    sdq_pkg::entry_t     item_reg, item_next;
    logic [1:0]          res_status_reg, res_status_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [ADDR_W-1:0]   head_reg, head_next;
    logic [CNT_W-1:0]    idx_reg, idx_next;
    logic [CNT_W-1:0]    take_reg, take_next;
    logic [31:0]         bound_reg, bound_next;
    logic [31:0]         eps_reg;

    logic                out_valid_reg, out_valid_next;
    logic [1:0]          status_reg, status_next;
    sdq_pkg::entry_t     out_entry_reg, out_entry_next;
    logic                last_reg, last_next;
    logic [5:0]          entries_reg, entries_next;

    // RAM control
    logic                ram_rd_en;
    logic [CNT_W-1:0]    ram_rd_idx;
    logic                ram_wr_en;
    logic [CNT_W-1:0]    ram_wr_idx;
    sdq_pkg::entry_t     ram_wr_data;
    sdq_pkg::entry_t     ram_rd_data;
    logic [ENTRY_W_L-1:0] ram_rd_bits;

    // Shared comparator and adder
    logic [31:0]         cmp_a, cmp_b;
    logic                cmp_le;
    logic [32:0]         bound_sum;
    logic [31:0]         bound_sat;

    logic                in_fire;
    logic                out_free;
    logic                emit_last;

    assign in_fire  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    assign ram_rd_data = sdq_pkg::entry_t'(ram_rd_bits);

    sdq_ram #(
        .WIDTH (ENTRY_W_L),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (wrap(head_reg, ram_wr_idx)),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (wrap(head_reg, ram_rd_idx)),
        .rd_data (ram_rd_bits)
    );

    // Insert scan: new <= stored; extract sizing: stored <= bound
    always_comb
    begin
        if (state_reg == sdq_pkg::ST_INS_SCAN)
        begin
            cmp_a = item_reg.delay;
            cmp_b = ram_rd_data.delay;
        end
        else
        begin
            cmp_a = ram_rd_data.delay;
            cmp_b = bound_reg;
        end
    end

    assign cmp_le    = cmp_a <= cmp_b;
    assign bound_sum = {1'b0, ram_rd_data.delay} + {1'b0, eps_reg};
    assign bound_sat = bound_sum[32] ? '1 : bound_sum[31:0];
    assign emit_last = (idx_reg + CNT_ONE) == take_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sdq_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = sdq_pkg::ST_DISPATCH;
                end
            end
            sdq_pkg::ST_DISPATCH:
            begin
                unique case (act_reg)
                    sdq_pkg::ACT_INSERT:
                    begin
                        if (count_reg == CNT_CAP)
                        begin
                            state_next = sdq_pkg::ST_RESULT;
                        end
                        else if (count_reg == '0)
                        begin
                            state_next = sdq_pkg::ST_INS_PUT;
                        end
                        else
                        begin
                            state_next = sdq_pkg::ST_INS_SCAN;
                        end
                    end
                    sdq_pkg::ACT_EXTRACT:
                    begin
                        state_next = (count_reg == '0) ? sdq_pkg::ST_RESULT
                                                       : sdq_pkg::ST_EXT_BOUND;
                    end
                    sdq_pkg::ACT_PEEK:
                    begin
                        state_next = (count_reg == '0) ? sdq_pkg::ST_RESULT
                                                       : sdq_pkg::ST_PEEK_LD;
                    end
                    default:
                    begin
                        state_next = sdq_pkg::ST_IDLE;
                    end
                endcase
            end
            sdq_pkg::ST_INS_SCAN:
            begin
                if (!cmp_le)
                begin
                    state_next = sdq_pkg::ST_RESULT;
                end
                else if (idx_reg == '0)
                begin
                    state_next = sdq_pkg::ST_INS_PUT;
                end
            end
            sdq_pkg::ST_INS_PUT:
            begin
                state_next = sdq_pkg::ST_RESULT;
            end
            sdq_pkg::ST_PEEK_LD:
            begin
                state_next = sdq_pkg::ST_RESULT;
            end
            sdq_pkg::ST_EXT_BOUND:
            begin
                state_next = (count_reg == CNT_ONE) ? sdq_pkg::ST_EMIT_RD
                                                    : sdq_pkg::ST_EXT_COUNT;
            end
            sdq_pkg::ST_EXT_COUNT:
            begin
                if (!cmp_le || (idx_reg + CNT_ONE) == count_reg)
                begin
                    state_next = sdq_pkg::ST_EMIT_RD;
                end
            end
            sdq_pkg::ST_EMIT_RD:
            begin
                state_next = sdq_pkg::ST_EMIT_LD;
            end
            sdq_pkg::ST_EMIT_LD:
            begin
                if (out_free)
                begin
                    state_next = emit_last ? sdq_pkg::ST_IDLE : sdq_pkg::ST_EMIT_RD;
                end
            end
            sdq_pkg::ST_RESULT:
            begin
                if (out_free)
                begin
                    state_next = sdq_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sdq_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs of the sequencer: RAM port control and input stall
    always_comb
    begin
        in_stall    = 1'b1;
        ram_rd_en   = 1'b0;
        ram_rd_idx  = '0;
        ram_wr_en   = 1'b0;
        ram_wr_idx  = '0;
        ram_wr_data = item_reg;
        unique case (state_reg)
            sdq_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
            end
            sdq_pkg::ST_DISPATCH:
            begin
                if (act_reg == sdq_pkg::ACT_INSERT)
                begin
                    ram_rd_en  = (count_reg != '0) && (count_reg != CNT_CAP);
                    ram_rd_idx = count_reg - CNT_ONE;
                end
                else
                begin
                    ram_rd_en  = (count_reg != '0);
                    ram_rd_idx = '0;
                end
            end
            sdq_pkg::ST_INS_SCAN:
            begin
                ram_wr_en  = 1'b1;
                ram_wr_idx = idx_reg + CNT_ONE;
                if (cmp_le)
                begin
                    // stored entry moves back one place
                    ram_wr_data = ram_rd_data;
                    ram_rd_en   = (idx_reg != '0);
                    ram_rd_idx  = idx_reg - CNT_ONE;
                end
            end
            sdq_pkg::ST_INS_PUT:
            begin
                ram_wr_en  = 1'b1;
                ram_wr_idx = '0;
            end
            sdq_pkg::ST_EXT_BOUND:
            begin
                ram_rd_en  = (count_reg != CNT_ONE);
                ram_rd_idx = CNT_ONE;
            end
            sdq_pkg::ST_EXT_COUNT:
            begin
                ram_rd_en  = cmp_le && ((idx_reg + CNT_ONE) != count_reg);
                ram_rd_idx = idx_reg + CNT_ONE;
            end
            sdq_pkg::ST_EMIT_RD:
            begin
                ram_rd_en  = 1'b1;
                ram_rd_idx = idx_reg;
            end
            sdq_pkg::ST_PEEK_LD,
            sdq_pkg::ST_EMIT_LD,
            sdq_pkg::ST_RESULT:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // Datapath next values
    always_comb
    begin
        act_next        = act_reg;
        item_next       = item_reg;
        res_status_next = res_status_reg;
        count_next      = count_reg;
        head_next       = head_reg;
        idx_next        = idx_reg;
        take_next       = take_reg;
        bound_next      = bound_reg;
        out_valid_next  = out_valid_reg && out_stall;
        status_next     = status_reg;
        out_entry_next  = out_entry_reg;
        last_next       = last_reg;
        entries_next    = entries_reg;

        case (state_reg)
            sdq_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    act_next          = action;
                    item_next.species = species_id;
                    item_next.reaction = reaction_id;
                    item_next.delay   = delay_time;
                end
            end
            sdq_pkg::ST_DISPATCH:
            begin
                res_status_next = sdq_pkg::STAT_OK;
                idx_next        = count_reg - CNT_ONE;
                if (act_reg == sdq_pkg::ACT_INSERT)
                begin
                    if (count_reg == CNT_CAP)
                    begin
                        res_status_next = sdq_pkg::STAT_FULL;
                    end
                end
                else if (count_reg == '0)
                begin
                    res_status_next = sdq_pkg::STAT_EMPTY;
                    item_next       = '0;
                end
            end
            sdq_pkg::ST_INS_SCAN:
            begin
                if (cmp_le)
                begin
                    idx_next = idx_reg - CNT_ONE;
                end
                else
                begin
                    count_next = count_reg + CNT_ONE;
                end
            end
            sdq_pkg::ST_INS_PUT:
            begin
                count_next = count_reg + CNT_ONE;
            end
            sdq_pkg::ST_PEEK_LD:
            begin
                item_next = ram_rd_data;
            end
            sdq_pkg::ST_EXT_BOUND:
            begin
                // the front always belongs to its own group
                bound_next = bound_sat;
                take_next  = CNT_ONE;
                idx_next   = (count_reg == CNT_ONE) ? '0 : CNT_ONE;
            end
            sdq_pkg::ST_EXT_COUNT:
            begin
                if (cmp_le)
                begin
                    take_next = take_reg + CNT_ONE;
                end
                if (!cmp_le || (idx_reg + CNT_ONE) == count_reg)
                begin
                    idx_next = '0;
                end
                else
                begin
                    idx_next = idx_reg + CNT_ONE;
                end
            end
            sdq_pkg::ST_EMIT_LD:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    status_next    = sdq_pkg::STAT_OK;
                    out_entry_next = ram_rd_data;
                    last_next      = emit_last;
                    entries_next   = 6'(count_reg - take_reg);
                    idx_next       = idx_reg + CNT_ONE;
                    if (emit_last)
                    begin
                        head_next  = wrap(head_reg, take_reg);
                        count_next = count_reg - take_reg;
                    end
                end
            end
            sdq_pkg::ST_RESULT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    status_next    = res_status_reg;
                    out_entry_next = item_reg;
                    last_next      = 1'b1;
                    entries_next   = 6'(count_reg);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sdq_pkg::ST_IDLE;
            count_reg     <= '0;
            head_reg      <= '0;
            out_valid_reg <= 1'b0;
            eps_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            head_reg      <= head_next;
            out_valid_reg <= out_valid_next;
            if (psel && penable && pwrite && pready &&
                paddr[2] == sdq_pkg::REG_TIE_EPSILON)
            begin
                eps_reg <= pwdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg        <= act_next;
        item_reg       <= item_next;
        res_status_reg <= res_status_next;
        idx_reg        <= idx_next;
        take_reg       <= take_next;
        bound_reg      <= bound_next;
        status_reg     <= status_next;
        out_entry_reg  <= out_entry_next;
        last_reg       <= last_next;
        entries_reg    <= entries_next;
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == sdq_pkg::REG_TIE_EPSILON) ? eps_reg : '0;

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign out_species    = out_entry_reg.species;
    assign out_reaction   = out_entry_reg.reaction;
    assign out_time       = out_entry_reg.delay;
    assign last           = last_reg;
    assign entries_in_use = entries_reg;

endmodule

// ===== src/sdq_checker.sv =====
module sdq_checker #(
    parameter int CAPACITY = 32
) (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_stall,
    input logic                         out_valid,
    input logic                         out_stall,
    input logic [1:0]                   status,
    input logic [15:0]                  out_species,
    input logic [15:0]                  out_reaction,
    input logic [31:0]                  out_time,
    input logic                         last,
    input logic [5:0]                   entries_in_use
);

    // one item in flight: a transfer in closes the input for the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input taken on two consecutive cycles");

    // empty results carry zero payload and close the item
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == sdq_pkg::STAT_EMPTY) |->
            (last && entries_in_use == '0 && out_species == '0 &&
             out_reaction == '0 && out_time == '0))
        else $error("empty result malformed");

    // a dropped insert only happens on a full store
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == sdq_pkg::STAT_FULL) |->
            (last && entries_in_use == 6'(CAPACITY)))
        else $error("full status with store not full");

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=>
            (out_valid && $stable(out_time) && $stable(last) && $stable(status)))
        else $error("stalled result changed");

endmodule

bind sorted_delay_event_queue_unit sdq_checker #(.CAPACITY(CAPACITY)) u_sdq_checker (.*);
